/* rtl/core/image_rotate_nearest_macros.svh */
// Assertion macros used by the checker
`ifndef IMAGE_ROTATE_NEAREST_MACROS_SVH
`define IMAGE_ROTATE_NEAREST_MACROS_SVH

// Implication checked on every edge outside reset
`define IRN_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Signal must hold while a beat is offered and not taken
`define IRN_ASSERT_HOLD(label, vld, rdy, sig) \
  label: assert property (@(posedge clk) disable iff (rst) ((vld) && !(rdy)) |=> $stable(sig)) \
    else $error("stalled beat changed");

// Signal must be low in the cycle after reset
`define IRN_ASSERT_RESET_LOW(label, sig) \
  label: assert property (@(posedge clk) rst |=> !(sig)) \
    else $error("signal not cleared by reset");

`endif

/* rtl/core/irn_pkg.sv */
package irn_pkg;

  // Geometry of the pixel store
  localparam int COORD_W    = 8;
  localparam int SOURCE_DIM = 1 << COORD_W;
  localparam int SIDE_W     = COORD_W + 1;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int PIX_W      = 32;

  // Fixed point datapath
  localparam int FRAC_BITS = 14;
  localparam int TRIG_W    = 16;
  localparam int DELTA_W   = COORD_W + 2;
  localparam int PROD_W    = TRIG_W + DELTA_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int RND_W     = SUM_W - FRAC_BITS;
  localparam int POS_W     = RND_W + 1;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

  // Item kinds
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  // Configuration register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_COS          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SIDE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_CTR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // One classified operation for the back end
  typedef struct packed {
    logic              load;   // write the store rather than read it
    logic              hit;    // load: in range; fetch: in frame and inside source
    logic [ADDR_W-1:0] addr;   // y in the upper half, x in the lower
    logic [PIX_W-1:0]  pixel;
  } op_t;

endpackage

/* rtl/core/irn_front.sv */
module irn_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [irn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [irn_pkg::COORD_W-1:0]    in_x,
  input  logic [irn_pkg::COORD_W-1:0]    in_y,
  input  logic [irn_pkg::PIX_W-1:0]      in_pixel,
  input  logic                           q_full,
  output logic                           push,
  output irn_pkg::op_t                   push_op
);

  // Configuration registers
  logic signed [irn_pkg::TRIG_W-1:0] cos_q14;
  logic signed [irn_pkg::TRIG_W-1:0] sin_q14;
  logic [irn_pkg::SIDE_W-1:0]        source_side;
  logic [irn_pkg::COORD_W-1:0]       source_centre;
  logic [irn_pkg::COORD_W-1:0]       shift_x;
  logic [irn_pkg::COORD_W-1:0]       shift_y;
  logic [irn_pkg::SIDE_W-1:0]        frame_width;
  logic [irn_pkg::SIDE_W-1:0]        frame_height;

  logic                              en;
  logic [irn_pkg::SIDE_W-1:0]        side_eff;
  logic                              load_ok;
  logic                              frame_ok;
  logic signed [irn_pkg::DELTA_W-1:0] dx;
  logic signed [irn_pkg::DELTA_W-1:0] dy;

  // Stage 1: offsets
  logic                               s1_valid;
  logic                               s1_load;
  logic                               s1_ok;
  logic signed [irn_pkg::DELTA_W-1:0] s1_dx;
  logic signed [irn_pkg::DELTA_W-1:0] s1_dy;
  logic [irn_pkg::ADDR_W-1:0]         s1_addr;
  logic [irn_pkg::PIX_W-1:0]          s1_pixel;

  // Stage 2: products
  logic                              s2_valid;
  logic                              s2_load;
  logic                              s2_ok;
  logic signed [irn_pkg::PROD_W-1:0] s2_pcx;
  logic signed [irn_pkg::PROD_W-1:0] s2_psy;
  logic signed [irn_pkg::PROD_W-1:0] s2_pcy;
  logic signed [irn_pkg::PROD_W-1:0] s2_psx;
  logic [irn_pkg::ADDR_W-1:0]        s2_addr;
  logic [irn_pkg::PIX_W-1:0]         s2_pixel;
  logic signed [irn_pkg::PROD_W-1:0] pcx;
  logic signed [irn_pkg::PROD_W-1:0] psy;
  logic signed [irn_pkg::PROD_W-1:0] pcy;
  logic signed [irn_pkg::PROD_W-1:0] psx;

  // Stage 3: rounded rotation
  logic                             s3_valid;
  logic                             s3_load;
  logic                             s3_ok;
  logic signed [irn_pkg::RND_W-1:0] s3_rx;
  logic signed [irn_pkg::RND_W-1:0] s3_ry;
  logic [irn_pkg::ADDR_W-1:0]       s3_addr;
  logic [irn_pkg::PIX_W-1:0]        s3_pixel;
  logic signed [irn_pkg::SUM_W-1:0] sum_x;
  logic signed [irn_pkg::SUM_W-1:0] sum_y;

  // Stage 4: classified operation
  logic                             s4_valid;
  irn_pkg::op_t                     s4_op;
  logic signed [irn_pkg::POS_W-1:0] sx;
  logic signed [irn_pkg::POS_W-1:0] sy;
  logic                             in_sx;
  logic                             in_sy;
  irn_pkg::op_t                     op_next;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_q14       <= irn_pkg::TRIG_W'(16384);
      sin_q14       <= '0;
      source_side   <= irn_pkg::SIDE_W'(irn_pkg::SOURCE_DIM);
      source_centre <= irn_pkg::COORD_W'(irn_pkg::SOURCE_DIM / 2);
      shift_x       <= '0;
      shift_y       <= '0;
      frame_width   <= irn_pkg::SIDE_W'(irn_pkg::SOURCE_DIM);
      frame_height  <= irn_pkg::SIDE_W'(irn_pkg::SOURCE_DIM);
    end else if (cfg_valid) begin
      case (cfg_index)
        irn_pkg::REG_COS:          cos_q14       <= cfg_data;
        irn_pkg::REG_SIN:          sin_q14       <= cfg_data;
        irn_pkg::REG_SOURCE_SIDE:  source_side   <= cfg_data[irn_pkg::SIDE_W-1:0];
        irn_pkg::REG_SOURCE_CTR:   source_centre <= cfg_data[irn_pkg::COORD_W-1:0];
        irn_pkg::REG_SHIFT_X:      shift_x       <= cfg_data[irn_pkg::COORD_W-1:0];
        irn_pkg::REG_SHIFT_Y:      shift_y       <= cfg_data[irn_pkg::COORD_W-1:0];
        irn_pkg::REG_FRAME_WIDTH:  frame_width   <= cfg_data[irn_pkg::SIDE_W-1:0];
        irn_pkg::REG_FRAME_HEIGHT: frame_height  <= cfg_data[irn_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipe advances together while the queue has room
  assign en       = !q_full;
  assign in_ready = en;

  // Classify and form offsets from the centre
  always_comb begin
    side_eff = (source_side > irn_pkg::SIDE_W'(irn_pkg::SOURCE_DIM))
             ? irn_pkg::SIDE_W'(irn_pkg::SOURCE_DIM) : source_side;
    load_ok  = ({1'b0, in_x} < side_eff) && ({1'b0, in_y} < side_eff);
    frame_ok = ({1'b0, in_x} < frame_width) && ({1'b0, in_y} < frame_height);
    dx = $signed({{(irn_pkg::DELTA_W-irn_pkg::COORD_W){1'b0}}, in_x})
       + $signed({{(irn_pkg::DELTA_W-irn_pkg::COORD_W){1'b0}}, shift_x})
       - $signed({{(irn_pkg::DELTA_W-irn_pkg::COORD_W){1'b0}}, source_centre});
    dy = $signed({{(irn_pkg::DELTA_W-irn_pkg::COORD_W){1'b0}}, in_y})
       + $signed({{(irn_pkg::DELTA_W-irn_pkg::COORD_W){1'b0}}, shift_y})
       - $signed({{(irn_pkg::DELTA_W-irn_pkg::COORD_W){1'b0}}, source_centre});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_load  <= (in_func == irn_pkg::FUNC_LOAD);
      s1_ok    <= (in_func == irn_pkg::FUNC_LOAD) ? load_ok : frame_ok;
      s1_dx    <= dx;
      s1_dy    <= dy;
      s1_addr  <= {in_y, in_x};
      s1_pixel <= in_pixel;
    end
  end

  // Four products of the rotation matrix
  always_comb begin
    pcx = cos_q14 * s1_dx;
    psy = sin_q14 * s1_dy;
    pcy = cos_q14 * s1_dy;
    psx = sin_q14 * s1_dx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_load  <= s1_load;
      s2_ok    <= s1_ok;
      s2_pcx   <= pcx;
      s2_psy   <= psy;
      s2_pcy   <= pcy;
      s2_psx   <= psx;
      s2_addr  <= s1_addr;
      s2_pixel <= s1_pixel;
    end
  end

  // Sum, add half and drop the fraction (floor)
  always_comb begin
    sum_x = s2_pcx + s2_psy + irn_pkg::ROUND_HALF;
    sum_y = s2_pcy - s2_psx + irn_pkg::ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_load  <= s2_load;
      s3_ok    <= s2_ok;
      s3_rx    <= sum_x[irn_pkg::SUM_W-1:irn_pkg::FRAC_BITS];
      s3_ry    <= sum_y[irn_pkg::SUM_W-1:irn_pkg::FRAC_BITS];
      s3_addr  <= s2_addr;
      s3_pixel <= s2_pixel;
    end
  end

  // Add the centre back and test against the source square
  always_comb begin
    sx = $signed({{(irn_pkg::POS_W-irn_pkg::COORD_W){1'b0}}, source_centre}) + s3_rx;
    sy = $signed({{(irn_pkg::POS_W-irn_pkg::COORD_W){1'b0}}, source_centre}) + s3_ry;
    in_sx = !sx[irn_pkg::POS_W-1] &&
            (sx[irn_pkg::POS_W-2:0] < {{(irn_pkg::POS_W-1-irn_pkg::SIDE_W){1'b0}}, side_eff});
    in_sy = !sy[irn_pkg::POS_W-1] &&
            (sy[irn_pkg::POS_W-2:0] < {{(irn_pkg::POS_W-1-irn_pkg::SIDE_W){1'b0}}, side_eff});
    op_next.load  = s3_load;
    op_next.pixel = s3_pixel;
    if (s3_load) begin
      op_next.hit  = s3_ok;
      op_next.addr = s3_addr;
    end else begin
      op_next.hit  = s3_ok && in_sx && in_sy;
      op_next.addr = {sy[irn_pkg::COORD_W-1:0], sx[irn_pkg::COORD_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_op <= op_next;
    end
  end

  // Hand the operation to the queue
  assign push    = en && s4_valid;
  assign push_op = s4_op;

endmodule

/* rtl/core/irn_queue.sv */
module irn_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  irn_pkg::op_t push_op,
  input  logic         pop,
  output irn_pkg::op_t head,
  output logic         empty,
  output logic         full
);

  irn_pkg::op_t                entries [irn_pkg::QUEUE_DEPTH];
  logic [irn_pkg::QPTR_W-1:0]  wr_ptr;
  logic [irn_pkg::QPTR_W-1:0]  rd_ptr;
  logic [irn_pkg::QCNT_W-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == irn_pkg::QCNT_W'(irn_pkg::QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  // Store pushed operations
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + irn_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + irn_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + irn_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - irn_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/irn_back.sv */
module irn_back (
  input  logic                      clk,
  input  logic                      rst,
  input  irn_pkg::op_t              head,
  input  logic                      empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [irn_pkg::PIX_W-1:0] out_pixel,
  output logic                      out_inside
);

  logic [irn_pkg::PIX_W-1:0] store [irn_pkg::SOURCE_DIM * irn_pkg::SOURCE_DIM];
  logic [irn_pkg::PIX_W-1:0] rd_data;
  logic                      rd_valid;
  logic                      rd_hit;
  logic                      out_adv;
  logic                      rd_adv;
  logic                      wr_en;
  logic                      rd_en;

  // Output register frees when empty or taken; read stage moves with it
  assign out_adv = !out_valid || out_ready;
  assign rd_adv  = !rd_valid || out_adv;
  assign pop     = !empty && (head.load || rd_adv);
  assign wr_en   = pop && head.load && head.hit;
  assign rd_en   = pop && !head.load && head.hit;

  // Pixel store: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[head.addr] <= head.pixel;
    end
    if (rd_en) begin
      rd_data <= store[head.addr];
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_adv) begin
      rd_valid <= pop && !head.load;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_adv) begin
      rd_hit <= head.hit;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && rd_valid) begin
      out_pixel  <= rd_hit ? rd_data : '0;
      out_inside <= rd_hit;
    end
  end

endmodule

/* rtl/core/image_rotate_nearest.sv */
// An accepted fetch beat passes the front stages, the queue, the read stage and the output register.
// Throughput: one beat per cycle while the queue has room and the output is not stalled; a load beat
// gives no result and writes the single-port pixel store only when in range; the store is used at most once per item.
// Reset clears the pipeline, the queue and the output register, and sets the registers
// to their defaults; the pixel store is not cleared and holds garbage until written.
module image_rotate_nearest (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [irn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [47:0]                    s_tdata,  // coord_x, coord_y, pixel_in
  input  logic                           s_tuser,  // func
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,  // pixel_out
  output logic                           m_tuser   // inside_res
);

  irn_pkg::op_t              push_op;
  irn_pkg::op_t              head;
  logic                      push;
  logic                      pop;
  logic                      q_empty;
  logic                      q_full;
  logic [irn_pkg::PIX_W-1:0] out_pixel;
  logic                      out_inside;

  // Registers take a write every cycle
  assign cfg_ready = 1'b1;

  irn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_x      (s_tdata[irn_pkg::COORD_W-1:0]),
    .in_y      (s_tdata[2*irn_pkg::COORD_W-1:irn_pkg::COORD_W]),
    .in_pixel  (s_tdata[2*irn_pkg::COORD_W+irn_pkg::PIX_W-1:2*irn_pkg::COORD_W]),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  irn_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  irn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_pixel  (out_pixel),
    .out_inside (out_inside)
  );

  // Pack the result beat
  assign m_tdata = out_pixel;
  assign m_tuser = out_inside;

endmodule

/* rtl/core/irn_checker.sv */
`include "image_rotate_nearest_macros.svh"

module irn_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // Stalled result beat holds
  `IRN_ASSERT_HOLD(a_valid_hold, m_tvalid, m_tready, m_tvalid)
  `IRN_ASSERT_HOLD(a_data_hold, m_tvalid, m_tready, m_tdata)

  // A point outside the source gives a zero pixel
  `IRN_ASSERT_IMPLY(a_outside_zero, m_tvalid && !m_tuser, m_tdata == 32'd0)

  // Reset empties the output register
  `IRN_ASSERT_RESET_LOW(a_reset_empty, m_tvalid)

endmodule

bind image_rotate_nearest irn_checker u_irn_checker (.*);
